// File: hdl/ordered_list_insert_remove_macros.svh
// Assertion macros for the ordered list block.
// Included by the controller and the datapath; needs clk_i and rst_ni in scope.
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`ifndef SYNTH
`define OLIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define OLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OLIR_ASSERT(lbl, prop, msg)
`define OLIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/olir_pkg.sv
// Package for the ordered list block: sizes, operation codes, entry layout
// and the command and status structs between controller and datapath.
`default_nettype none

package olir_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 16;
  localparam int KEY_BITS    = 32;
  localparam int KIND_BITS   = 3;
  localparam int POS_BITS    = 6;
  localparam int COUNT_BITS  = 7;

  localparam int IDX_BITS   = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int WIDE_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
  localparam int ENTRY_BITS = HANDLE_BITS + KEY_BITS;

  localparam logic [KIND_BITS-1:0] KIND_APPEND     = KIND_BITS'(0);
  localparam logic [KIND_BITS-1:0] KIND_INSERT     = KIND_BITS'(1);
  localparam logic [KIND_BITS-1:0] KIND_READ       = KIND_BITS'(2);
  localparam logic [KIND_BITS-1:0] KIND_FIND       = KIND_BITS'(3);
  localparam logic [KIND_BITS-1:0] KIND_REMOVE_KEY = KIND_BITS'(4);
  localparam logic [KIND_BITS-1:0] KIND_REMOVE_POS = KIND_BITS'(5);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    key;
  } entry_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_LAST,
    IDX_POS,
    IDX_INC,
    IDX_DEC,
    IDX_PREV_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_NEW,
    WR_SHR,
    WR_SHL
  } wr_op_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_FAIL,
    CAP_ITEM,
    CAP_RD
  } cap_op_e;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    wr_op_e  wr_op;
    cap_op_e cap_op;
    logic    count_inc;
    logic    count_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic                 full;
    logic                 count_zero;
    logic                 pos_lt_count;
    logic                 idx_eq_pos;
    logic                 idx_eq_last;
    logic                 prev_eq_last;
    logic                 key_match;
    logic                 out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/olir_in_if.sv
// Input channel of the ordered list block: handshake and operation payload.
// Depends on olir_pkg.
`default_nettype none

interface olir_in_if;
  import olir_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   kind;
  logic [POS_BITS-1:0]    position;
  logic [HANDLE_BITS-1:0] handle;
  logic [KEY_BITS-1:0]    key;

  modport source (output valid, kind, position, handle, key, input ready);
  modport sink (input valid, kind, position, handle, key, output ready);
endinterface

`default_nettype wire

// File: hdl/olir_out_if.sv
// Result channel of the ordered list block: handshake and result payload.
// Depends on olir_pkg.
`default_nettype none

interface olir_out_if;
  import olir_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [HANDLE_BITS-1:0] result_handle;
  logic [COUNT_BITS-1:0]  count;

  modport source (output valid, ok, result_handle, count, input ready);
  modport sink (input valid, ok, result_handle, count, output ready);
endinterface

`default_nettype wire

// File: hdl/olir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module olir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/olir_ctrl.sv
// Controller of the ordered list block: sequences dispatch, scan, shift and
// result stages. Depends on olir_pkg and the assertion macro header.
`default_nettype none
`include "ordered_list_insert_remove_macros.svh"

module olir_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  olir_pkg::sts_t sts_i,
  output olir_pkg::cmd_t cmd_o
);
  import olir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_WRITE,
    S_SHR,
    S_SHR_END,
    S_RD,
    S_RD_DATA,
    S_SCAN,
    S_SCAN_TAIL,
    S_SHL,
    S_SHL_END,
    S_FIN_REMOVE,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   moving_q, moving_d;

  always_comb begin
    state_d    = state_q;
    moving_d   = moving_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        moving_d = 1'b0;
        unique case (sts_i.kind) inside
          KIND_APPEND, KIND_INSERT: begin
            if (sts_i.full) begin
              cmd_o.cap_op = CAP_FAIL;
              state_d      = S_DONE;
            end else if ((sts_i.kind == KIND_INSERT) && sts_i.pos_lt_count) begin
              cmd_o.idx_op = IDX_LAST;
              state_d      = S_SHR;
            end else begin
              cmd_o.idx_op = IDX_COUNT;
              state_d      = S_WRITE;
            end
          end
          KIND_READ, KIND_REMOVE_POS: begin
            if (sts_i.pos_lt_count) begin
              cmd_o.idx_op = IDX_POS;
              state_d      = S_RD;
            end else begin
              cmd_o.cap_op = CAP_FAIL;
              state_d      = S_DONE;
            end
          end
          KIND_FIND, KIND_REMOVE_KEY: begin
            if (sts_i.count_zero) begin
              cmd_o.cap_op = CAP_FAIL;
              state_d      = S_DONE;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_SCAN;
            end
          end
          default: begin
            cmd_o.cap_op = CAP_FAIL;
            state_d      = S_DONE;
          end
        endcase
      end
      S_WRITE: begin
        cmd_o.wr_op     = WR_NEW;
        cmd_o.cap_op    = CAP_ITEM;
        cmd_o.count_inc = 1'b1;
        state_d         = S_DONE;
      end
      S_SHR: begin
        moving_d    = 1'b1;
        cmd_o.wr_op = moving_q ? WR_SHR : WR_NONE;
        if (sts_i.idx_eq_pos) begin
          state_d = S_SHR_END;
        end else begin
          cmd_o.idx_op = IDX_DEC;
        end
      end
      S_SHR_END: begin
        cmd_o.wr_op = WR_SHR;
        state_d     = S_WRITE;
      end
      S_RD: begin
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.cap_op = CAP_RD;
        if (sts_i.kind == KIND_READ) begin
          state_d = S_DONE;
        end else if (sts_i.idx_eq_last) begin
          state_d = S_FIN_REMOVE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          moving_d     = 1'b0;
          state_d      = S_SHL;
        end
      end
      S_SCAN: begin
        moving_d = 1'b1;
        if (moving_q && sts_i.key_match) begin
          cmd_o.cap_op = CAP_RD;
          if (sts_i.kind == KIND_FIND) begin
            state_d = S_DONE;
          end else if (sts_i.prev_eq_last) begin
            state_d = S_FIN_REMOVE;
          end else begin
            cmd_o.idx_op = IDX_PREV_INC;
            moving_d     = 1'b0;
            state_d      = S_SHL;
          end
        end else if (sts_i.idx_eq_last) begin
          state_d = S_SCAN_TAIL;
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_SCAN_TAIL: begin
        if (sts_i.key_match) begin
          cmd_o.cap_op = CAP_RD;
          state_d      = (sts_i.kind == KIND_FIND) ? S_DONE : S_FIN_REMOVE;
        end else begin
          cmd_o.cap_op = CAP_FAIL;
          state_d      = S_DONE;
        end
      end
      S_SHL: begin
        moving_d    = 1'b1;
        cmd_o.wr_op = moving_q ? WR_SHL : WR_NONE;
        if (sts_i.idx_eq_last) begin
          state_d = S_SHL_END;
        end else begin
          cmd_o.idx_op = IDX_INC;
        end
      end
      S_SHL_END: begin
        cmd_o.wr_op     = WR_SHL;
        cmd_o.count_dec = 1'b1;
        state_d         = S_DONE;
      end
      S_FIN_REMOVE: begin
        cmd_o.count_dec = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      moving_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      moving_q <= moving_d;
    end
  end

  `OLIR_ASSERT(a_out_load_free, !cmd_o.out_load || sts_i.out_free, "Result loaded while busy")
  `OLIR_ASSERT(a_new_not_full, (cmd_o.wr_op != WR_NEW) || !sts_i.full, "Entry written when full")
  `OLIR_ASSERT(a_ready_idle, !in_ready_o || (state_q == S_IDLE), "Input ready outside idle")

endmodule

`default_nettype wire

// File: hdl/olir_dp.sv
// Datapath of the ordered list block: operation register, entry RAM, index,
// entry count and result register. Depends on olir_pkg, olir_ram and the macros.
`default_nettype none
`include "ordered_list_insert_remove_macros.svh"

module olir_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [olir_pkg::KIND_BITS-1:0]   kind_i,
  input  logic [olir_pkg::POS_BITS-1:0]    position_i,
  input  logic [olir_pkg::HANDLE_BITS-1:0] handle_i,
  input  logic [olir_pkg::KEY_BITS-1:0]    key_i,
  input  olir_pkg::cmd_t                   cmd_i,
  output olir_pkg::sts_t                   sts_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_ok_o,
  output logic [olir_pkg::HANDLE_BITS-1:0] out_handle_o,
  output logic [olir_pkg::COUNT_BITS-1:0]  out_count_o
);
  import olir_pkg::*;

  logic [KIND_BITS-1:0]   kind_q;
  logic [POS_BITS-1:0]    pos_q;
  logic [HANDLE_BITS-1:0] hnd_in_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [IDX_BITS-1:0]    idx_q, idx_d;
  logic [IDX_BITS-1:0]    prev_idx_q;
  logic [IDX_BITS-1:0]    last_idx;
  logic [CNT_BITS-1:0]    count_q;
  logic                   ok_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic                   out_valid_q;
  logic                   out_ok_q;
  logic [HANDLE_BITS-1:0] out_hnd_q;
  logic [COUNT_BITS-1:0]  out_cnt_q;

  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr;
  entry_t                 ram_wdata;
  entry_t                 rd_data;
  logic [ENTRY_BITS-1:0]  rd_bits;

  assign last_idx = IDX_BITS'(count_q - CNT_BITS'(1));
  assign rd_data  = entry_t'(rd_bits);

  always_comb begin
    unique case (cmd_i.idx_op)
      IDX_HOLD:     idx_d = idx_q;
      IDX_ZERO:     idx_d = '0;
      IDX_COUNT:    idx_d = IDX_BITS'(count_q);
      IDX_LAST:     idx_d = last_idx;
      IDX_POS:      idx_d = IDX_BITS'(pos_q);
      IDX_INC:      idx_d = idx_q + IDX_BITS'(1);
      IDX_DEC:      idx_d = idx_q - IDX_BITS'(1);
      IDX_PREV_INC: idx_d = prev_idx_q + IDX_BITS'(1);
      default:      idx_d = idx_q;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = rd_data;
    unique case (cmd_i.wr_op)
      WR_NONE: ram_we = 1'b0;
      WR_NEW: begin
        ram_we    = 1'b1;
        ram_wdata = '{handle: hnd_in_q, key: key_q};
      end
      WR_SHR: begin
        ram_we    = 1'b1;
        ram_waddr = prev_idx_q + IDX_BITS'(1);
      end
      WR_SHL: begin
        ram_we    = 1'b1;
        ram_waddr = prev_idx_q - IDX_BITS'(1);
      end
      default: ram_we = 1'b0;
    endcase
  end

  olir_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ENTRY_BITS'(ram_wdata)),
    .raddr_i (idx_q),
    .rdata_o (rd_bits)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      pos_q    <= position_i;
      hnd_in_q <= handle_i;
      key_q    <= key_i;
    end
    case (cmd_i.cap_op)
      CAP_FAIL: begin
        ok_q  <= 1'b0;
        hnd_q <= '0;
      end
      CAP_ITEM: begin
        ok_q  <= 1'b1;
        hnd_q <= hnd_in_q;
      end
      CAP_RD: begin
        ok_q  <= 1'b1;
        hnd_q <= rd_data.handle;
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      out_ok_q  <= ok_q;
      out_hnd_q <= hnd_q;
      out_cnt_q <= COUNT_BITS'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      prev_idx_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      prev_idx_q <= idx_q;
      if (cmd_i.count_inc) begin
        count_q <= count_q + CNT_BITS'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CNT_BITS'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.kind         = kind_q;
    sts_o.full         = (count_q == CNT_BITS'(CAPACITY));
    sts_o.count_zero   = (count_q == '0);
    sts_o.pos_lt_count = (WIDE_BITS'(pos_q) < WIDE_BITS'(count_q));
    sts_o.idx_eq_pos   = (WIDE_BITS'(idx_q) == WIDE_BITS'(pos_q));
    sts_o.idx_eq_last  = (idx_q == last_idx);
    sts_o.prev_eq_last = (prev_idx_q == last_idx);
    sts_o.key_match    = (rd_data.key == key_q);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_handle_o = out_hnd_q;
  assign out_count_o  = out_cnt_q;

  `OLIR_ASSERT(a_count_bound, count_q <= CNT_BITS'(CAPACITY), "Entry count above capacity")
  `OLIR_ASSERT(a_dec_not_empty, !cmd_i.count_dec || (count_q != '0), "Removal from empty list")
  `OLIR_ASSERT_NEXT(a_inc_step, cmd_i.count_inc, count_q == $past(count_q) + CNT_BITS'(1), "Bad count step")

endmodule

`default_nettype wire

// File: hdl/ordered_list_insert_remove.sv
// Ordered list of (handle, key) entries in a single entry RAM, one transaction at a time.
// Dispatch refuses unknown kinds, append and insert on a full list, read and removal by
// position out of range, and find and removal by key on an empty list. Insert before the
// end shifts later entries up, search by key scans from the first entry, removal shifts
// later entries down. The next transaction can be accepted as the result becomes valid.
// Reset clears the entry count and the handshakes; RAM contents are left as they are.
`default_nettype none

module ordered_list_insert_remove (
  input  logic              clk_i,
  input  logic              rst_ni,
  olir_in_if.sink           in_i,
  olir_out_if.source        out_o
);
  import olir_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  olir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  olir_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (in_i.kind),
    .position_i   (in_i.position),
    .handle_i     (in_i.handle),
    .key_i        (in_i.key),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_ok_o     (out_o.ok),
    .out_handle_o (out_o.result_handle),
    .out_count_o  (out_o.count)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

// File: dv/ordered_list_insert_remove_test.sv
// Self-checking testbench for ordered_list_insert_remove: drives list operations with random
// gaps and stalls and checks every result against its own tracked copy of the list.
// Depends on olir_pkg, olir_in_if, olir_out_if and the ordered_list_insert_remove RTL.
`timescale 1ns / 100ps

module ordered_list_insert_remove_test;
  import olir_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_SPARE_A = KIND_BITS'(6);
  localparam logic [KIND_BITS-1:0] KIND_SPARE_B = KIND_BITS'(7);
  localparam int TARGET_OPS = 1950;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic                   ok;
    logic [HANDLE_BITS-1:0] handle;
    logic [COUNT_BITS-1:0]  count;
  } list_result_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} op_mix_e;

  class list_tracker;
    entry_t       slots[CAPACITY];
    int           fill;
    list_result_t awaited[$];
    int           errors;
    int           checked;
    int           refused;
    int           times_full;
    int           times_empty;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      refused = 0;
      times_full = 0;
      times_empty = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [HANDLE_BITS-1:0] take_at(int slot);
      logic [HANDLE_BITS-1:0] hnd;
      hnd = slots[slot].handle;
      for (int i = slot; i + 1 < fill; i++) slots[i] = slots[i + 1];
      fill--;
      if (fill == 0) times_empty++;
      return hnd;
    endfunction

    function int key_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < fill; i++) begin
        if (slots[i].key == key) return i;
      end
      return -1;
    endfunction

    function void apply_operation(logic [KIND_BITS-1:0] kind, logic [POS_BITS-1:0] pos,
                                  logic [HANDLE_BITS-1:0] hnd, logic [KEY_BITS-1:0] key);
      list_result_t res;
      int slot;
      res = '0;
      case (kind)
        KIND_APPEND, KIND_INSERT: begin
          if (fill < CAPACITY) begin
            slot = fill;
            if (kind == KIND_INSERT && int'(pos) < fill) begin
              slot = pos;
              for (int i = fill; i > slot; i--) slots[i] = slots[i - 1];
            end
            slots[slot].handle = hnd;
            slots[slot].key = key;
            fill++;
            if (fill == CAPACITY) times_full++;
            res.ok = 1'b1;
            res.handle = hnd;
          end
        end
        KIND_READ: begin
          if (int'(pos) < fill) begin
            res.ok = 1'b1;
            res.handle = slots[pos].handle;
          end
        end
        KIND_FIND: begin
          slot = key_slot(key);
          if (slot >= 0) begin
            res.ok = 1'b1;
            res.handle = slots[slot].handle;
          end
        end
        KIND_REMOVE_KEY: begin
          slot = key_slot(key);
          if (slot >= 0) begin
            res.ok = 1'b1;
            res.handle = take_at(slot);
          end
        end
        KIND_REMOVE_POS: begin
          if (int'(pos) < fill) begin
            res.ok = 1'b1;
            res.handle = take_at(pos);
          end
        end
        default: ;
      endcase
      if (!res.ok) refused++;
      res.count = COUNT_BITS'(fill);
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic ok, logic [HANDLE_BITS-1:0] hnd,
                               logic [COUNT_BITS-1:0] cnt);
      list_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ok %0b handle %0h count %0d",
                 $time, ok, hnd, cnt);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("ok", want.ok, ok);
      compare_field("result_handle", want.handle, hnd);
      compare_field("count", want.count, cnt);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  olir_in_if  in_ch();
  olir_out_if out_ch();

  ordered_list_insert_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  list_tracker tracker = new();
  int  sent = 0;
  int  idle_cycles = 0;
  bit  request_gaps_on = 1'b1;
  bit  result_stalls_on = 1'b1;
  bit  out_of_reset = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  task automatic issue_op(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] pos,
                          input logic [HANDLE_BITS-1:0] hnd, input logic [KEY_BITS-1:0] key);
    int gap;
    gap = request_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.position = pos;
    in_ch.handle = hnd;
    in_ch.key = key;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    tracker.apply_operation(kind, pos, hnd, key);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_settled();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (tracker.fill > 0 && r < 60) return tracker.slots[$urandom_range(0, tracker.fill - 1)].key;
    if (r < 80) return KEY_BITS'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic logic [POS_BITS-1:0] pick_position();
    int p;
    if ($urandom_range(0, 99) < 80) p = $urandom_range(0, tracker.fill);
    else p = $urandom_range(0, CAPACITY - 1);
    if (p > CAPACITY - 1) p = CAPACITY - 1;
    return POS_BITS'(p);
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HANDLE_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic random_op(input op_mix_e mix);
    int cut[6];
    int r;
    logic [KIND_BITS-1:0] kind;
    case (mix)
      MIX_GROW:   cut = '{35, 65, 73, 81, 88, 96};
      MIX_SHRINK: cut = '{10, 20, 30, 40, 68, 96};
      default:    cut = '{20, 40, 55, 70, 82, 96};
    endcase
    r = $urandom_range(0, 99);
    if (r < cut[0]) kind = KIND_APPEND;
    else if (r < cut[1]) kind = KIND_INSERT;
    else if (r < cut[2]) kind = KIND_READ;
    else if (r < cut[3]) kind = KIND_FIND;
    else if (r < cut[4]) kind = KIND_REMOVE_KEY;
    else if (r < cut[5]) kind = KIND_REMOVE_POS;
    else kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    issue_op(kind, pick_position(), pick_handle(), pick_key());
  endtask

  always begin
    int stall;
    if (!out_of_reset) begin
      out_ch.ready = 1'b0;
      wait (out_of_reset);
    end
    stall = result_stalls_on ? $urandom_range(0, 7) : 0;
    if (stall > 0) begin
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_ch.ready = 1'b1;
    @(posedge clk_i);
    while (!out_ch.valid) @(posedge clk_i);
    tracker.check_result(out_ch.ok, out_ch.result_handle, out_ch.count);
    @(negedge clk_i);
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("[ordered_list_insert_remove] ERROR");
    $finish;
  end

  initial begin
    int phase_no;
    op_mix_e mix;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.position = '0;
    in_ch.handle = '0;
    in_ch.key = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    out_of_reset = 1'b1;

    issue_op(KIND_READ, '0, '0, '0);
    issue_op(KIND_FIND, '0, '0, '0);
    issue_op(KIND_REMOVE_KEY, '0, '0, '1);
    issue_op(KIND_REMOVE_POS, '1, '0, '0);
    issue_op(KIND_SPARE_A, '0, 16'h1111, 32'h1);
    issue_op(KIND_SPARE_B, '1, '1, '1);
    issue_op(KIND_APPEND, '1, '1, '1);
    issue_op(KIND_APPEND, '0, '0, '0);
    issue_op(KIND_INSERT, '0, 16'h1234, 32'h5);
    issue_op(KIND_INSERT, '1, 16'h5678, 32'h5);
    issue_op(KIND_INSERT, POS_BITS'(1), 16'h9abc, 32'hdead_beef);
    issue_op(KIND_READ, '0, '0, '0);
    issue_op(KIND_READ, POS_BITS'(tracker.fill - 1), '0, '0);
    issue_op(KIND_READ, POS_BITS'(tracker.fill), '0, '0);
    issue_op(KIND_FIND, '0, '0, 32'h5);
    issue_op(KIND_REMOVE_KEY, '0, '0, 32'h5);
    issue_op(KIND_FIND, '0, '0, 32'h5);
    issue_op(KIND_FIND, '0, '0, 32'h1234_5678);
    issue_op(KIND_REMOVE_POS, '0, '0, '0);
    issue_op(KIND_REMOVE_POS, '1, '0, '0);
    issue_op(KIND_REMOVE_POS, POS_BITS'(tracker.fill - 1), '0, '0);
    issue_op(KIND_FIND, '0, '0, '1);
    issue_op(KIND_REMOVE_KEY, '0, '0, '0);

    hold_until_settled();
    while (tracker.fill < CAPACITY) begin
      issue_op($urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT, pick_position(),
               pick_handle(), pick_key());
    end
    issue_op(KIND_APPEND, '0, '1, '1);
    issue_op(KIND_INSERT, '0, '1, '1);
    issue_op(KIND_READ, '1, '0, '0);
    while (tracker.fill > 0) begin
      if ($urandom_range(0, 1)) issue_op(KIND_REMOVE_POS, pick_position(), '0, '0);
      else issue_op(KIND_REMOVE_KEY, '0, '0, pick_key());
    end
    issue_op(KIND_REMOVE_POS, '0, '0, '0);

    phase_no = 0;
    while (sent < TARGET_OPS) begin
      mix = op_mix_e'($urandom_range(0, 2));
      request_gaps_on = $urandom_range(0, 3) != 0;
      result_stalls_on = $urandom_range(0, 3) != 0;
      if (phase_no == 0 || $urandom_range(0, 1)) hold_until_settled();
      repeat ($urandom_range(40, 160)) random_op(mix);
      phase_no++;
    end

    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, tracker.pending());
      tracker.errors++;
    end
    $display("Checked %0d transactions, %0d of them refused, over %0d random phases.",
             tracker.checked, tracker.refused, phase_no);
    $display("The list was filled %0d times and emptied %0d times.",
             tracker.times_full, tracker.times_empty);
    if (tracker.errors == 0) begin
      $display("[ordered_list_insert_remove] OK");
    end else begin
      $display("[ordered_list_insert_remove] ERROR");
    end
    $finish;
  end

endmodule
